// ===== rtl/core/mbrh_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrh_pkg: shared types and constants
// Opcodes, reply codes, sequencer states and the CRC step function.
// ----------------------------------------------------------------------------
package mbrh_pkg;

    localparam int REG_DEPTH_DEF      = 256;
    localparam int TX_CAPACITY_DEF    = 64;
    localparam int MAX_SLAVE_ADDR_DEF = 247;

    localparam int FRAME_LEN   = 8;
    localparam int REPLY_FIXED = 5;
    localparam int RESULT_LIMIT = 63;

    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_TX_IDLE = 2'd2;
    localparam logic [1:0] OP_REG_WR  = 2'd3;

    localparam logic [7:0] FN_READ      = 8'h03;
    localparam logic [7:0] EXC_FLAG     = 8'h80;
    localparam logic [7:0] EXC_FUNCTION = 8'h01;
    localparam logic [7:0] EXC_ADDRESS  = 8'h02;
    localparam logic [7:0] EXC_VALUE    = 8'h03;

    localparam logic [1:0] CFG_OWN_ADDR  = 2'd0;
    localparam logic [1:0] CFG_REG_COUNT = 2'd1;
    localparam logic [1:0] CFG_GAP       = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RXCRC,
        ST_CHECK,
        ST_HDR,
        ST_RDREQ,
        ST_RDWAIT,
        ST_DATA,
        ST_CRCLO,
        ST_CRCHI,
        ST_STATUS
    } state_t;

    // one bit step of CRC-16/MODBUS
    function automatic logic [15:0] crc_bit(input logic [15:0] c);
        crc_bit = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    endfunction

endpackage

// ===== rtl/core/mbrh_crc.sv =====
// ----------------------------------------------------------------------------
// mbrh_crc: shared CRC-16/MODBUS unit
// Takes a byte on start, shifts one bit per cycle, holds busy high until all eight bits are shifted.
// ----------------------------------------------------------------------------
module mbrh_crc (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        clear,
    input  logic        start,
    input  logic [7:0]  din,
    output logic        busy,
    output logic [15:0] crc
);
    import mbrh_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [3:0]  cnt_reg, cnt_next;

    always_comb begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (clear) begin
            crc_next = 16'hFFFF;
            cnt_next = 4'd0;
        end else if (start) begin
            crc_next = crc_reg ^ {8'h00, din};
            cnt_next = 4'd8;
        end else if (cnt_reg != 4'd0) begin
            crc_next = crc_bit(crc_reg);
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= 16'hFFFF;
            cnt_reg <= 4'd0;
        end else begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy = (cnt_reg != 4'd0);
    assign crc  = crc_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy)
        else $error("crc start while busy");
    a_count_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !clear) |=> (cnt_reg == 4'd8))
        else $error("crc count not loaded");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 4'd8)
        else $error("crc count overflow");
endmodule

// ===== rtl/core/mbrh_hold_mem.sv =====
// ----------------------------------------------------------------------------
// mbrh_hold_mem: holding register store
// One write port, one registered read port; per-entry valid bits give zero reset.
// ----------------------------------------------------------------------------
module mbrh_hold_mem #(
    parameter int REG_DEPTH = mbrh_pkg::REG_DEPTH_DEF,
    parameter int AW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);
    import mbrh_pkg::*;

    logic [15:0]          mem [REG_DEPTH];
    logic [REG_DEPTH-1:0] vld_reg;
    logic [15:0]          q_reg;
    logic                 qv_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            qv_reg  <= 1'b0;
        end else begin
            if (wr_en) vld_reg[wr_addr] <= 1'b1;
            if (rd_en) qv_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = qv_reg ? q_reg : 16'h0000;
endmodule

// ===== rtl/core/modbus_read_holding_slave_core.sv =====
// ----------------------------------------------------------------------------
// modbus_read_holding_slave_core: Modbus RTU slave, function 3 only
// Collects request frames, checks them with a shared bit-serial CRC unit and
// streams the reply bytes from the holding store.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low first)                 | tuser
// s_axis  | in  | rx_byte, reg_index, reg_value            | opcode
// m_axis  | out | tx_byte, waiting_tx,                     | has_byte
//         |     | requests_seen, replies_sent, errors_seen | (tlast = last)
// cfg     | in  | wr_en, wr_index, wr_data                 | -
//
// Each item that does not complete a frame yields one status item before the
// next is accepted. A completed frame has its six request bytes checked bit by
// bit through the single CRC unit; a dropped frame then yields a status item,
// else the reply header and data bytes pass bit by bit through that unit too.
// Reset is synchronous and clears control state and the holding store valid
// bits. s_axis_tready is low while an item is in work; m_axis stalls hold it.
// ----------------------------------------------------------------------------
module modbus_read_holding_slave_core #(
    parameter int REG_DEPTH      = mbrh_pkg::REG_DEPTH_DEF,
    parameter int TX_CAPACITY    = mbrh_pkg::TX_CAPACITY_DEF,
    parameter int MAX_SLAVE_ADDR = mbrh_pkg::MAX_SLAVE_ADDR_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rx_byte[7:0], reg_index[15:8], reg_value[31:16]
    input  logic [31:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], waiting_tx[8], requests_seen[24:9],
    // replies_sent[40:25], errors_seen[56:41]
    output logic [63:0] m_axis_tdata,
    // has_byte[0]
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data
);
    import mbrh_pkg::*;

    localparam int AW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
    localparam int LIM_A = (TX_CAPACITY - REPLY_FIXED) / 2;
    localparam int LIM_B = (RESULT_LIMIT - REPLY_FIXED) / 2;
    localparam int LIMIT = (LIM_A < LIM_B) ? LIM_A : LIM_B;
    localparam int EFF_MAX = (REG_DEPTH < 511) ? REG_DEPTH : 511;

    // configuration
    logic [7:0]  own_reg;
    logic [8:0]  rcnt_reg;
    logic [15:0] gap_reg, tmo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg  <= 8'd1;
            rcnt_reg <= 9'd0;
            gap_reg  <= 16'd4;
            tmo_reg  <= 16'd100;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_OWN_ADDR:  own_reg  <= cfg_wr_data[7:0];
                CFG_REG_COUNT: rcnt_reg <= cfg_wr_data[8:0];
                CFG_GAP:       gap_reg  <= cfg_wr_data;
                CFG_TIMEOUT:   tmo_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic inert;
    assign inert = (own_reg == 8'd0) || (own_reg > 8'(MAX_SLAVE_ADDR)) ||
                   (rcnt_reg == 9'd0) || (gap_reg == 16'd0);
    logic [8:0] eff;
    assign eff = (rcnt_reg > 9'(EFF_MAX)) ? 9'(EFF_MAX) : rcnt_reg;

    // input fields
    logic [1:0]  in_op;
    logic [7:0]  in_byte, in_idx;
    logic [15:0] in_val;
    assign in_op   = s_axis_tuser;
    assign in_byte = s_axis_tdata[7:0];
    assign in_idx  = s_axis_tdata[15:8];
    assign in_val  = s_axis_tdata[31:16];

    // state
    state_t      st_reg, st_next;
    logic [7:0]  frame_reg [FRAME_LEN];
    logic [3:0]  fill_reg;
    logic        wait_reg;
    logic [15:0] idle_reg, txel_reg;
    logic [15:0] req_reg, rep_reg, err_reg;
    logic [2:0]  bi_reg;         // byte index for CRC scan
    logic [7:0]  hdr_reg [3];    // reply header bytes
    logic [1:0]  hn_reg;         // header length-1 index
    logic [1:0]  hi_reg;
    logic        exc_reg;
    logic [8:0]  addr_reg;
    logic [5:0]  left_reg;       // data registers left
    logic        lo_reg;         // next data byte is low half
    logic [15:0] word_reg;
    logic        crc_pend_reg;   // crc unit has a byte in flight
    logic [7:0]  ob_reg;
    logic        oh_reg, ol_reg, ov_reg;

    logic        accept;
    assign s_axis_tready = (st_reg == ST_IDLE) && !ov_reg;
    assign accept = s_axis_tvalid && s_axis_tready;

    logic        out_free;
    assign out_free = !ov_reg || m_axis_tready;

    logic        frame_done;
    assign frame_done = accept && !inert && (in_op == OP_RX_BYTE) && !wait_reg &&
                        (fill_reg == 4'(FRAME_LEN - 1));

    // crc unit
    logic        crc_clr, crc_start, crc_busy;
    logic [7:0]  crc_din;
    logic [15:0] crc_val;
    mbrh_crc u_crc (
        .aclk(aclk), .aresetn(aresetn), .clear(crc_clr), .start(crc_start),
        .din(crc_din), .busy(crc_busy), .crc(crc_val)
    );

    logic        crc_ready;
    assign crc_ready = !crc_busy && !crc_pend_reg;

    // holding store
    logic        mem_we, mem_re;
    logic [15:0] mem_q;
    logic [AW-1:0] mem_ra;
    assign mem_we = accept && !inert && (in_op == OP_REG_WR) &&
                    ({9'd0, in_idx} < 17'(REG_DEPTH));
    assign mem_re = (st_reg == ST_RDREQ);
    assign mem_ra = AW'(addr_reg);
    mbrh_hold_mem #(.REG_DEPTH(REG_DEPTH), .AW(AW)) u_mem (
        .aclk(aclk), .aresetn(aresetn), .wr_en(mem_we), .wr_addr(AW'(in_idx)),
        .wr_data(in_val), .rd_en(mem_re), .rd_addr(mem_ra), .rd_data(mem_q)
    );

    // frame decode
    logic [15:0] f_start, f_count, f_rxcrc;
    assign f_start = {frame_reg[2], frame_reg[3]};
    assign f_count = {frame_reg[4], frame_reg[5]};
    assign f_rxcrc = {frame_reg[7], frame_reg[6]};

    logic       frame_drop;
    assign frame_drop = (crc_val != f_rxcrc) || (frame_reg[0] != own_reg);

    // next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (accept)
                    st_next = frame_done ? ST_RXCRC : ST_STATUS;
            end
            ST_RXCRC: begin
                if (crc_ready && bi_reg == 3'd6)
                    st_next = ST_CHECK;
            end
            ST_CHECK: st_next = frame_drop ? ST_STATUS : ST_HDR;
            ST_HDR: begin
                if (crc_ready && out_free && hi_reg == hn_reg)
                    st_next = exc_reg ? ST_CRCLO : ST_RDREQ;
            end
            ST_RDREQ:  st_next = ST_RDWAIT;
            ST_RDWAIT: st_next = ST_DATA;
            ST_DATA: begin
                if (crc_ready && out_free && lo_reg)
                    st_next = (left_reg == 6'd1) ? ST_CRCLO : ST_RDREQ;
            end
            ST_CRCLO: begin
                if (crc_ready && out_free)
                    st_next = ST_CRCHI;
            end
            ST_CRCHI: begin
                if (out_free)
                    st_next = ST_IDLE;
            end
            ST_STATUS: begin
                if (out_free)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // crc feed and emit strobes
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;
    always_comb begin
        crc_clr   = 1'b0;
        crc_start = 1'b0;
        crc_din   = 8'h00;
        emit      = 1'b0;
        emit_byte = 8'h00;
        emit_last = 1'b0;
        case (st_reg)
            ST_IDLE: crc_clr = frame_done;
            ST_RXCRC: begin
                if (crc_ready && bi_reg != 3'd6) begin
                    crc_start = 1'b1;
                    crc_din   = frame_reg[bi_reg];
                end
            end
            ST_CHECK: crc_clr = 1'b1;
            ST_HDR: begin
                if (crc_ready && out_free) begin
                    emit      = 1'b1;
                    emit_byte = hdr_reg[hi_reg];
                    crc_start = 1'b1;
                    crc_din   = hdr_reg[hi_reg];
                end
            end
            ST_DATA: begin
                if (crc_ready && out_free) begin
                    emit      = 1'b1;
                    emit_byte = lo_reg ? word_reg[7:0] : word_reg[15:8];
                    crc_start = 1'b1;
                    crc_din   = lo_reg ? word_reg[7:0] : word_reg[15:8];
                end
            end
            ST_CRCLO: begin
                if (crc_ready && out_free) begin
                    emit      = 1'b1;
                    emit_byte = crc_val[7:0];
                end
            end
            ST_CRCHI: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_byte = crc_val[15:8];
                    emit_last = 1'b1;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            fill_reg     <= 4'd0;
            wait_reg     <= 1'b0;
            idle_reg     <= 16'd0;
            txel_reg     <= 16'd0;
            req_reg      <= 16'd0;
            rep_reg      <= 16'd0;
            err_reg      <= 16'd0;
            ov_reg       <= 1'b0;
            crc_pend_reg <= 1'b0;
            bi_reg       <= 3'd0;
            hi_reg       <= 2'd0;
        end else begin
            st_reg       <= st_next;
            crc_pend_reg <= crc_start;
            if (m_axis_tready) ov_reg <= 1'b0;
            if (emit) begin
                ov_reg <= 1'b1;
                ob_reg <= emit_byte;
                ol_reg <= emit_last;
                oh_reg <= (st_reg != ST_STATUS);
            end
            case (st_reg)
                ST_IDLE: begin
                    bi_reg <= 3'd0;
                    hi_reg <= 2'd0;
                    if (accept && !inert) begin
                        case (in_op)
                            OP_RX_BYTE: begin
                                if (!wait_reg) begin
                                    frame_reg[fill_reg[2:0]] <= in_byte;
                                    fill_reg <= fill_reg + 4'd1;
                                    idle_reg <= 16'd0;
                                end
                            end
                            OP_TICK: begin
                                if (wait_reg) begin
                                    if (txel_reg != 16'hFFFF &&
                                        txel_reg + 16'd1 < tmo_reg)
                                        txel_reg <= txel_reg + 16'd1;
                                    else if (txel_reg == 16'hFFFF &&
                                             txel_reg < tmo_reg)
                                        txel_reg <= txel_reg;
                                    else begin
                                        err_reg  <= err_reg + 16'd1;
                                        wait_reg <= 1'b0;
                                        txel_reg <= 16'd0;
                                        fill_reg <= 4'd0;
                                        idle_reg <= 16'd0;
                                    end
                                end else if (fill_reg != 4'd0) begin
                                    if (idle_reg != 16'hFFFF &&
                                        idle_reg + 16'd1 < gap_reg)
                                        idle_reg <= idle_reg + 16'd1;
                                    else if (idle_reg == 16'hFFFF &&
                                             idle_reg < gap_reg)
                                        idle_reg <= idle_reg;
                                    else begin
                                        err_reg  <= err_reg + 16'd1;
                                        fill_reg <= 4'd0;
                                        idle_reg <= 16'd0;
                                    end
                                end
                            end
                            OP_TX_IDLE: begin
                                if (wait_reg) begin
                                    wait_reg <= 1'b0;
                                    txel_reg <= 16'd0;
                                    fill_reg <= 4'd0;
                                    idle_reg <= 16'd0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RXCRC: begin
                    if (crc_start) bi_reg <= bi_reg + 3'd1;
                    if (st_next == ST_CHECK) begin
                        req_reg  <= req_reg + 16'd1;
                        fill_reg <= 4'd0;
                        idle_reg <= 16'd0;
                    end
                end
                ST_CHECK: begin
                    hdr_reg[0] <= own_reg;
                    hn_reg     <= 2'd2;
                    exc_reg    <= 1'b1;
                    addr_reg   <= f_start[8:0];
                    left_reg   <= f_count[5:0];
                    lo_reg     <= 1'b0;
                    if (crc_val != f_rxcrc) begin
                        err_reg <= err_reg + 16'd1;
                    end else if (frame_reg[0] == own_reg) begin
                        if (frame_reg[1] != FN_READ) begin
                            hdr_reg[1] <= frame_reg[1] | EXC_FLAG;
                            hdr_reg[2] <= EXC_FUNCTION;
                            err_reg    <= err_reg + 16'd1;
                        end else if (f_count == 16'd0) begin
                            hdr_reg[1] <= FN_READ | EXC_FLAG;
                            hdr_reg[2] <= EXC_VALUE;
                            err_reg    <= err_reg + 16'd1;
                        end else if (f_start >= {7'd0, eff} ||
                                     f_count > {7'd0, eff} - f_start) begin
                            hdr_reg[1] <= FN_READ | EXC_FLAG;
                            hdr_reg[2] <= EXC_ADDRESS;
                            err_reg    <= err_reg + 16'd1;
                        end else if (f_count > 16'(LIMIT)) begin
                            hdr_reg[1] <= FN_READ | EXC_FLAG;
                            hdr_reg[2] <= EXC_VALUE;
                            err_reg    <= err_reg + 16'd1;
                        end else begin
                            hdr_reg[1] <= FN_READ;
                            hdr_reg[2] <= {f_count[6:0], 1'b0};
                            exc_reg    <= 1'b0;
                        end
                        rep_reg  <= rep_reg + 16'd1;
                        wait_reg <= 1'b1;
                        txel_reg <= 16'd0;
                    end
                end
                ST_HDR: if (emit) hi_reg <= hi_reg + 2'd1;
                ST_RDWAIT: word_reg <= mem_q;
                ST_DATA: begin
                    if (emit) begin
                        lo_reg <= !lo_reg;
                        if (lo_reg) begin
                            left_reg <= left_reg - 6'd1;
                            addr_reg <= addr_reg + 9'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = oh_reg;
    assign m_axis_tdata  = {7'd0, err_reg, rep_reg, req_reg, wait_reg,
                            oh_reg ? ob_reg : 8'h00};

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !ov_reg)
        else $error("ready with output pending");
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 4'(FRAME_LEN))
        else $error("frame fill overflow");
    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_DATA) |-> (left_reg != 6'd0))
        else $error("data phase with no bytes left");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
         $stable(m_axis_tlast)))
        else $error("output changed while stalled");
endmodule
